// File: hdl/tspb_pkg.sv
package tspb_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int SCALED_W = 10;
    localparam int BEND_W   = 14;
    localparam int CHAN_W   = 5;
    localparam int RUN_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // shared divider widths: dividend covers the largest scaled product,
    // divisor covers the mapping span and the averaging depth
    localparam int DIV_NW = 24;
    localparam int DIV_DW = 10;

    // constants of the mapping
    localparam logic [SCALED_W-1:0] SCALED_MAX = 10'd1023;
    localparam logic [BEND_W-1:0]   BEND_SPAN  = 14'd16383;
    localparam logic [RUN_W-1:0]    RUN_MAX    = 8'd255;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELTA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL     = 3'd5;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_UPD,
        S_MEAN,
        S_MUL,
        S_MAP,
        S_FIN,
        S_EMIT
    } t_state;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

endpackage

// File: hdl/tspb_ram.sv
module tspb_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/tspb_div.sv
module tspb_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tspb_pkg::t_div_req         i_req,
    output logic                       o_done,
    output logic [tspb_pkg::DIV_NW-1:0] o_quotient
);

    localparam int NW  = tspb_pkg::DIV_NW;
    localparam int DW  = tspb_pkg::DIV_DW;
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_quo, n_quo;
    logic [DW-1:0]    r_rem, n_rem;
    logic [DW-1:0]    r_dvs, n_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DW:0]      rem_sh;
    logic [DW:0]      rem_sub;

    // one restoring step per cycle, quotient bits shift in from the right
    always_comb begin
        rem_sh  = {r_rem, r_quo[NW-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_cnt  = CNT_W'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_dvs}) begin
                n_rem = rem_sub[DW-1:0];
                n_quo = {r_quo[NW-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DW-1:0];
                n_quo = {r_quo[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // checks
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == CNT_W'(1) && !i_req.start) |=> (r_done && !r_busy))
        else $error("divider missed its done pulse");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == '0)
        else $error("divider count left over while idle");

endmodule

// File: hdl/touch_strip_pitch_bend_conditioner.sv
// Touch strip pitch bend conditioner. Each 12-bit sample is scaled to 0..1023;
// a reading below the touch threshold sends one zero bend (if the last bend was
// not zero), any other reading enters an AVG_DEPTH-entry ring whose mean is
// range checked against the threshold minus the hysteresis, run counted for
// finger-down and lift, mapped from threshold..1023 to -8192..8191 and sent
// when it moves by at least min_delta or on finger-down. One 24-bit radix-2
// divider does both the mean and the mapping division; the mapping division is
// skipped when the threshold is 1023, and a reading below the threshold uses no
// division. A bend that finds the output register still holding a stalled beat
// waits for that beat. o_in_stall is high whenever the sequencer is not idle.
// A finished bend waits in an output register, and the next sample is taken
// meanwhile. Registers are to be written through i_cfg_we/i_cfg_index/i_cfg_data
// only while the block is idle; the block itself does not enforce this.
module touch_strip_pitch_bend_conditioner #(
    parameter int AVG_DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [tspb_pkg::SAMPLE_W-1:0]       i_raw_sample,
    // bend channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tspb_pkg::BEND_W-1:0]  o_bend_value,
    output logic [tspb_pkg::CHAN_W-1:0]         o_bend_channel,
    // register writes
    input  logic                                i_cfg_we,
    input  logic [tspb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tspb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SW    = tspb_pkg::SCALED_W;
    localparam int BW    = tspb_pkg::BEND_W;
    localparam int RW    = tspb_pkg::RUN_W;
    localparam int NW    = tspb_pkg::DIV_NW;
    localparam int DW    = tspb_pkg::DIV_DW;
    localparam int WP_W  = $clog2(AVG_DEPTH);
    localparam int SUM_W = $clog2(AVG_DEPTH * 1023 + 1);
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(AVG_DEPTH * 1023);

    // configuration registers
    logic [SW-1:0]     r_touch_min;
    logic [7:0]        r_hyst;
    logic [BW-1:0]     r_min_delta;
    logic [RW-1:0]     r_enter;
    logic [RW-1:0]     r_exit;
    logic [tspb_pkg::CHAN_W-1:0] r_chan;

    // sequencer and item state
    tspb_pkg::t_state  r_state, n_state;
    logic [SW-1:0]     r_scaled, n_scaled;
    logic [WP_W-1:0]   r_wp, n_wp;
    logic [AVG_DEPTH-1:0] r_vld, n_vld;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SW-1:0]     r_mean, n_mean;
    logic signed [BW-1:0] r_last, n_last;
    logic [RW-1:0]     r_in_run, n_in_run;
    logic [RW-1:0]     r_out_run, n_out_run;
    logic              r_neg, n_neg;
    logic              r_entry, n_entry;
    logic signed [BW-1:0] r_mapped, n_mapped;
    logic signed [BW-1:0] r_pend, n_pend;

    // output register
    logic              r_out_valid, n_out_valid;
    logic              out_load;
    logic signed [BW-1:0] r_out_value;
    logic [tspb_pkg::CHAN_W-1:0] r_out_chan;

    // history ring and divider
    logic              ram_we;
    logic [SW-1:0]     ram_rdata;
    tspb_pkg::t_div_req div_req;
    logic              div_done;
    logic [NW-1:0]     div_quo;

    // datapath helpers
    logic [SW-1:0]     hist_old;
    logic [SUM_W-1:0]  sum_upd;
    logic [WP_W-1:0]   wp_next;
    logic [SW-1:0]     mean_q;
    logic              in_range;
    logic [RW-1:0]     in_inc;
    logic [RW-1:0]     out_inc;
    logic signed [SW:0] map_diff;
    logic [SW-1:0]     map_mag;
    logic [NW-1:0]     map_prod;
    logic [DW-1:0]     map_span;
    logic signed [NW+1:0] q_signed;
    logic signed [NW+1:0] map_v;
    logic signed [BW-1:0] map_clamped;
    logic signed [BW:0] upd_diff;
    logic [BW:0]       upd_abs;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_min <= 10'd460;
            r_hyst      <= 8'd20;
            r_min_delta <= 14'd100;
            r_enter     <= 8'd3;
            r_exit      <= 8'd3;
            r_chan      <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tspb_pkg::CFG_TOUCH_MIN:   r_touch_min <= i_cfg_data[SW-1:0];
                tspb_pkg::CFG_HYSTERESIS:  r_hyst      <= i_cfg_data[7:0];
                tspb_pkg::CFG_MIN_DELTA:   r_min_delta <= i_cfg_data[BW-1:0];
                tspb_pkg::CFG_ENTER_COUNT: r_enter     <= i_cfg_data[RW-1:0];
                tspb_pkg::CFG_EXIT_COUNT:  r_exit      <= i_cfg_data[RW-1:0];
                tspb_pkg::CFG_CHANNEL:     r_chan      <= i_cfg_data[tspb_pkg::CHAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ring update and mean range test
    always_comb begin
        hist_old = r_vld[r_wp] ? ram_rdata : '0;
        sum_upd  = r_sum - SUM_W'(hist_old) + SUM_W'(r_scaled);
        wp_next  = (r_wp == WP_W'(AVG_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        mean_q   = div_quo[SW-1:0];
        in_range = ({1'b0, mean_q} + {3'b000, r_hyst}) >= {1'b0, r_touch_min};
        in_inc   = (r_in_run == tspb_pkg::RUN_MAX) ? r_in_run : r_in_run + 1'b1;
        out_inc  = (r_out_run == tspb_pkg::RUN_MAX) ? r_out_run : r_out_run + 1'b1;
    end

    // mapping: magnitude product, then signed quotient, offset and clamp
    always_comb begin
        map_diff = $signed({1'b0, r_mean}) - $signed({1'b0, r_touch_min});
        map_mag  = map_diff[SW] ? SW'(-map_diff) : map_diff[SW-1:0];
        map_prod = NW'({{(NW-SW){1'b0}}, map_mag} * {{(NW-BW){1'b0}}, tspb_pkg::BEND_SPAN});
        map_span = tspb_pkg::SCALED_MAX - r_touch_min;
        q_signed = r_neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
        map_v    = q_signed - (NW+2)'(8192);
        if (map_v < -(NW+2)'(8192)) begin
            map_clamped = -14'sd8192;
        end else if (map_v > (NW+2)'(8191)) begin
            map_clamped = 14'sd8191;
        end else begin
            map_clamped = map_v[BW-1:0];
        end
        upd_diff = $signed({r_mapped[BW-1], r_mapped}) - $signed({r_last[BW-1], r_last});
        upd_abs  = upd_diff[BW] ? (BW+1)'(-upd_diff) : upd_diff;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_scaled  = r_scaled;
        n_wp      = r_wp;
        n_vld     = r_vld;
        n_sum     = r_sum;
        n_mean    = r_mean;
        n_last    = r_last;
        n_in_run  = r_in_run;
        n_out_run = r_out_run;
        n_neg     = r_neg;
        n_entry   = r_entry;
        n_mapped  = r_mapped;
        n_pend    = r_pend;
        ram_we    = 1'b0;
        out_load  = 1'b0;
        div_req   = '{start: 1'b0, dividend: '0, divisor: '0};
        unique case (r_state)
            tspb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_scaled = i_raw_sample[tspb_pkg::SAMPLE_W-1:2];
                    n_state  = tspb_pkg::S_CHK;
                end
            end
            tspb_pkg::S_CHK: begin
                if (r_scaled < r_touch_min) begin
                    if (r_last != '0) begin
                        n_last  = '0;
                        n_pend  = '0;
                        n_state = tspb_pkg::S_EMIT;
                    end else begin
                        n_state = tspb_pkg::S_IDLE;
                    end
                end else begin
                    n_state = tspb_pkg::S_UPD;
                end
            end
            tspb_pkg::S_UPD: begin
                ram_we        = 1'b1;
                n_vld[r_wp]   = 1'b1;
                n_sum         = sum_upd;
                n_wp          = wp_next;
                div_req.start    = 1'b1;
                div_req.dividend = NW'(sum_upd);
                div_req.divisor  = DW'(AVG_DEPTH);
                n_state = tspb_pkg::S_MEAN;
            end
            tspb_pkg::S_MEAN: begin
                if (div_done) begin
                    n_mean = mean_q;
                    if (in_range) begin
                        n_out_run = '0;
                        n_in_run  = in_inc;
                        if (r_last == '0 && in_inc >= r_enter) begin
                            n_in_run = '0;
                            n_entry  = 1'b1;
                            n_state  = tspb_pkg::S_MUL;
                        end else if (r_last != '0) begin
                            n_entry = 1'b0;
                            n_state = tspb_pkg::S_MUL;
                        end else begin
                            n_state = tspb_pkg::S_IDLE;
                        end
                    end else begin
                        n_in_run  = '0;
                        n_out_run = out_inc;
                        if (r_last != '0 && out_inc >= r_exit) begin
                            n_last  = '0;
                            n_pend  = '0;
                            n_state = tspb_pkg::S_EMIT;
                        end else begin
                            n_state = tspb_pkg::S_IDLE;
                        end
                    end
                end
            end
            tspb_pkg::S_MUL: begin
                if (r_touch_min == tspb_pkg::SCALED_MAX) begin
                    n_mapped = 14'sd8191;
                    n_state  = tspb_pkg::S_FIN;
                end else begin
                    n_neg            = map_diff[SW];
                    div_req.start    = 1'b1;
                    div_req.dividend = map_prod;
                    div_req.divisor  = map_span;
                    n_state          = tspb_pkg::S_MAP;
                end
            end
            tspb_pkg::S_MAP: begin
                if (div_done) begin
                    n_mapped = map_clamped;
                    n_state  = tspb_pkg::S_FIN;
                end
            end
            tspb_pkg::S_FIN: begin
                if (r_entry || upd_abs >= {1'b0, r_min_delta}) begin
                    n_last  = r_mapped;
                    n_pend  = r_mapped;
                    n_state = tspb_pkg::S_EMIT;
                end else begin
                    n_state = tspb_pkg::S_IDLE;
                end
            end
            tspb_pkg::S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = tspb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tspb_pkg::S_IDLE;
            end
        endcase
    end

    // output slot
    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tspb_pkg::S_IDLE;
            r_wp        <= '0;
            r_vld       <= '0;
            r_sum       <= '0;
            r_last      <= '0;
            r_in_run    <= '0;
            r_out_run   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_vld       <= n_vld;
            r_sum       <= n_sum;
            r_last      <= n_last;
            r_in_run    <= n_in_run;
            r_out_run   <= n_out_run;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_scaled <= n_scaled;
        r_mean   <= n_mean;
        r_neg    <= n_neg;
        r_entry  <= n_entry;
        r_mapped <= n_mapped;
        r_pend   <= n_pend;
        if (out_load) begin
            r_out_value <= r_pend;
            r_out_chan  <= r_chan;
        end
    end

    // history ring: old entry read while the threshold check runs
    tspb_ram #(
        .WIDTH (SW),
        .DEPTH (AVG_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_scaled),
        .i_raddr (r_wp),
        .o_rdata (ram_rdata)
    );

    // shared divider for mean and mapping
    tspb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_in_stall     = (r_state != tspb_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_bend_value   = r_out_value;
    assign o_bend_channel = r_out_chan;

    // checks
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= WP_W'(AVG_DEPTH - 1))
        else $error("write pointer past ring end");

    a_runs_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_run != '0 && r_out_run != '0))
        else $error("in-range and out-of-range runs both active");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum <= SUM_MAX)
        else $error("running sum out of bound");

    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && o_bend_value == $past(r_pend)))
        else $error("emitted beat not presented");

endmodule
